[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files of the SIP header tagger.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SMHT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define SMHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

[sv/smht_pkg.sv]
// ----------------------------------------------------------------------------
// smht_pkg
// Types, constants and lookup tables of the SIP message header tagger.
// ----------------------------------------------------------------------------
`default_nettype none

package smht_pkg;

   localparam int MAX_LINE    = 512;
   localparam int MAX_HEADERS = 32;
   localparam int METHOD_BUF  = 32;

   localparam int LINE_POS_W  = $clog2(MAX_LINE);
   localparam int HDR_CNT_W   = $clog2(MAX_HEADERS + 1);

   localparam int PREFIX_LEN     = 7;
   localparam int METHOD_LEN_MAX = 31;
   localparam int STATUS_POS0    = 8;
   localparam int STATUS_POS1    = 9;
   localparam int STATUS_POS2    = 10;
   localparam int NUM_NAMES      = 6;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_SP      = 8'h20;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_CALL_ID = 2'd1;
   localparam logic [1:0] KIND_FROM    = 2'd2;
   localparam logic [1:0] KIND_TO      = 2'd3;

   localparam logic [7:0] RESP_PREFIX [PREFIX_LEN] = '{"S", "I", "P", "/", "2", ".", "0"};

   // Header names in lower case, zero padded, with their lengths and kinds.
   localparam logic [7:0] HDR_NAME [NUM_NAMES][8] = '{
      '{"c", "a", "l", "l", "-", "i", "d", 8'h00},
      '{"i", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "r", "o", "m", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] HDR_LEN [NUM_NAMES] = '{4'd7, 4'd1, 4'd4, 4'd1, 4'd2, 4'd1};
   localparam logic [1:0] HDR_KIND [NUM_NAMES] = '{
      KIND_CALL_ID, KIND_CALL_ID, KIND_FROM, KIND_FROM, KIND_TO, KIND_TO
   };

   typedef enum logic [1:0] {
      PH_START,
      PH_HDR,
      PH_DONE
   } smht_phase_type;

   typedef struct packed {
      smht_phase_type          phase;
      logic [LINE_POS_W-1:0]   line_pos;
      logic [HDR_CNT_W-1:0]    header_count;
      logic [NUM_NAMES-1:0]    name_mask;
      logic                    colon_seen;
      logic                    value_started;
      logic [1:0]              current_kind;
      logic                    pending_cr;
      logic                    prefix_match;
      logic                    method_open;
      logic [15:0]             held_status;
   } smht_state_type;

   typedef struct packed {
      logic [7:0]  echo_byte;
      logic        in_start_line;
      logic        response_flag;
      logic        method_done;
      logic [4:0]  method_length;
      logic        status_valid;
      logic [23:0] status_chars;
      logic [1:0]  value_kind;
      logic        value_commit;
      logic        line_term;
      logic        no_first_line;
      logic        last_result;
   } smht_result_type;

   // Up to two results produced by one input transaction.
   typedef struct packed {
      logic [1:0]      count;
      smht_result_type slot0;
      smht_result_type slot1;
   } smht_push_type;

   typedef struct packed {
      smht_state_type  st;
      smht_result_type res;
   } smht_slot_type;

   function automatic smht_state_type reset_state();
      smht_state_type s;
      s               = '0;
      s.phase         = PH_START;
      s.name_mask     = '1;
      s.prefix_match  = 1'b1;
      s.method_open   = 1'b1;
      return s;
   endfunction

endpackage

`default_nettype wire

[sv/smht_if.sv]
// ----------------------------------------------------------------------------
// smht_if
// Valid/ready channels for payload bytes and tagged results.
// ----------------------------------------------------------------------------
`default_nettype none

interface smht_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface smht_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  echo_byte;
   logic        in_start_line;
   logic        response_flag;
   logic        method_done;
   logic [4:0]  method_length;
   logic        status_valid;
   logic [23:0] status_chars;
   logic [1:0]  value_kind;
   logic        value_commit;
   logic        line_term;
   logic        no_first_line;
   logic        last_result;

   modport source (output valid, echo_byte, in_start_line, response_flag, method_done,
                   method_length, status_valid, status_chars, value_kind, value_commit,
                   line_term, no_first_line, last_result, input ready);
   modport sink   (input valid, echo_byte, in_start_line, response_flag, method_done,
                   method_length, status_valid, status_chars, value_kind, value_commit,
                   line_term, no_first_line, last_result, output ready);
endinterface

`default_nettype wire

[sv/sip_message_header_tagger_unit.sv]
// ----------------------------------------------------------------------------
// sip_message_header_tagger_unit
// Tags start-line facts and Call-ID, From and To header values of a SIP
// message streamed one byte per transaction.
// ----------------------------------------------------------------------------
// Usage: payload bytes enter on req_chan with a last-byte mark. Every byte
// comes back as one transaction on rsp_chan, in order, carrying the byte and
// its tags. Until the header block ends, a carriage return gives no result
// when it arrives; its result is issued together with the following byte, so
// that transaction yields two results back to back unless that byte is held
// back as well. A carriage return marked last is plain content. One byte is
// accepted per cycle as long as results are taken. The byte sits in an input
// register while the parse logic classifies it, then its results go into a
// four-entry result queue, from whose head they are offered.
// When the receiver stalls, the queue absorbs results; input stops once
// fewer than two free entries remain, and the input register holds the
// waiting byte. Reset empties the queue and the input register and returns
// the parser to the start of a message. After the last byte of a message the
// parser returns to that same state by itself.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_message_header_tagger_unit import smht_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   smht_req_if.sink   req_chan,
   smht_rsp_if.source rsp_chan
);

   // Results of one accepted byte, toward the queue.
   smht_push_type push;
   // The queue can take a two-result burst this cycle.
   logic          fifo_room;

   smht_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .fifo_room (fifo_room),
      .push      (push)
   );

   smht_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .fifo_room (fifo_room),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

[sv/smht_parser.sv]
// ----------------------------------------------------------------------------
// smht_parser
// Input register, parse state and the single-pass byte classification.
// ----------------------------------------------------------------------------
`default_nettype none

module smht_parser import smht_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   smht_req_if.sink     req,
   input  wire logic    fifo_room,
   output smht_push_type push
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            in_last_ff, in_last_in;
   smht_state_type  state_ff, state_in;

   smht_state_type  step_state;
   smht_push_type   step_push;
   logic            consume;
   logic            accept;

   function automatic logic resp_now(input smht_state_type s);
      if (s.phase == PH_START) begin
         return s.prefix_match && (s.line_pos >= LINE_POS_W'(PREFIX_LEN));
      end
      return s.prefix_match;
   endfunction

   function automatic logic [4:0] cap_len(input logic [LINE_POS_W-1:0] n);
      return (n > LINE_POS_W'(METHOD_LEN_MAX)) ? 5'(METHOD_LEN_MAX) : 5'(n);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c inside {[CH_UPPER_A:CH_UPPER_Z]}) ? c + CASE_DELTA : c;
   endfunction

   // One ordinary content byte of a line.
   function automatic smht_slot_type content_step(input smht_state_type s,
                                                  input logic [7:0] b);
      smht_slot_type          o;
      logic [LINE_POS_W-1:0]  p;
      logic [NUM_NAMES-1:0]   mask;
      logic                   hit;
      logic [2:0]             k;
      o               = '0;
      o.st            = s;
      o.res.echo_byte = b;
      p               = s.line_pos;
      mask            = s.name_mask;
      hit             = 1'b0;
      if (p < LINE_POS_W'(MAX_LINE - 1)) begin
         if (s.phase == PH_START) begin
            o.res.in_start_line = 1'b1;
            if (p < LINE_POS_W'(PREFIX_LEN) && b != RESP_PREFIX[p[2:0]]) begin
               o.st.prefix_match = 1'b0;
            end
            if (o.st.method_open && (b == CH_SP || p == LINE_POS_W'(METHOD_BUF - 1))) begin
               o.st.method_open = 1'b0;
               if (!(o.st.prefix_match && p >= LINE_POS_W'(PREFIX_LEN))) begin
                  o.res.method_done   = 1'b1;
                  o.res.method_length = cap_len(p);
               end
            end
            if (p == LINE_POS_W'(STATUS_POS0)) begin
               o.st.held_status = (b inside {[CH_ZERO:CH_NINE]}) ? {b, 8'h00} : 16'h0000;
            end else if (p == LINE_POS_W'(STATUS_POS1)) begin
               o.st.held_status[7:0] = o.st.held_status[7:0] | b;
            end else if (p == LINE_POS_W'(STATUS_POS2) && o.st.prefix_match &&
                         o.st.held_status[15:8] != 8'h00) begin
               o.res.status_valid = 1'b1;
               o.res.status_chars = {o.st.held_status, b};
            end
         end else if (s.phase == PH_HDR) begin
            if (!s.colon_seen) begin
               if (b == CH_COLON) begin
                  o.st.colon_seen   = 1'b1;
                  o.st.current_kind = KIND_NONE;
                  for (k = 3'd0; k < 3'(NUM_NAMES); k++) begin
                     if (LINE_POS_W'(HDR_LEN[k]) != p) begin
                        mask[k] = 1'b0;
                     end
                  end
                  for (k = 3'd0; k < 3'(NUM_NAMES); k++) begin
                     if (!hit && mask[k]) begin
                        o.st.current_kind = HDR_KIND[k];
                        hit               = 1'b1;
                     end
                  end
               end else begin
                  for (k = 3'd0; k < 3'(NUM_NAMES); k++) begin
                     if (p >= LINE_POS_W'(HDR_LEN[k]) || to_lower(b) != HDR_NAME[k][p[2:0]]) begin
                        mask[k] = 1'b0;
                     end
                  end
               end
               o.st.name_mask = mask;
            end else if (s.value_started || b != CH_SP) begin
               o.st.value_started = 1'b1;
               o.res.value_kind   = s.current_kind;
            end
         end
         o.st.line_pos = p + 1'b1;
      end
      o.res.response_flag = resp_now(o.st);
      return o;
   endfunction

   // A line feed that completes a terminator.
   function automatic smht_slot_type terminate_step(input smht_state_type s);
      smht_slot_type o;
      o               = '0;
      o.st            = s;
      o.res.echo_byte = CH_LF;
      o.res.line_term = 1'b1;
      if (s.phase == PH_START) begin
         o.st.prefix_match = s.prefix_match && (s.line_pos >= LINE_POS_W'(PREFIX_LEN));
         if (s.method_open && !o.st.prefix_match) begin
            o.res.method_done   = 1'b1;
            o.res.method_length = cap_len(s.line_pos);
         end
         o.st.method_open = 1'b0;
         o.st.phase       = PH_HDR;
      end else if (s.phase == PH_HDR) begin
         if (s.line_pos == '0) begin
            o.st.phase = PH_DONE;
         end else begin
            o.res.value_commit = 1'b1;
            o.res.value_kind   = s.colon_seen ? s.current_kind : KIND_NONE;
            o.st.header_count  = s.header_count + 1'b1;
            if (o.st.header_count >= HDR_CNT_W'(MAX_HEADERS)) begin
               o.st.phase = PH_DONE;
            end
         end
      end
      o.st.line_pos      = '0;
      o.st.name_mask     = '1;
      o.st.colon_seen    = 1'b0;
      o.st.value_started = 1'b0;
      o.st.current_kind  = KIND_NONE;
      o.res.response_flag = resp_now(o.st);
      return o;
   endfunction

   assign consume   = in_valid_ff && fifo_room;
   assign req.ready = !in_valid_ff || consume;
   assign accept    = req.valid && req.ready;

   // Parse step on the registered byte. Until PH_DONE, a carriage return not
   // marked last waits for the following byte to tell if it starts a CRLF pair.
   always_comb begin
      smht_state_type  st;
      smht_slot_type   sl;
      smht_result_type r0, r1;
      logic [1:0]      n;
      logic            handled;
      st      = state_ff;
      sl      = '0;
      r0      = '0;
      r1      = '0;
      n       = 2'd0;
      handled = 1'b0;
      if (st.phase == PH_DONE) begin
         r0.echo_byte     = in_byte_ff;
         r0.response_flag = resp_now(st);
         n                = 2'd1;
      end else begin
         if (st.pending_cr) begin
            st.pending_cr = 1'b0;
            if (in_byte_ff == CH_LF) begin
               r0.echo_byte     = CH_CR;
               r0.response_flag = resp_now(st);
               sl               = terminate_step(st);
               st               = sl.st;
               r1               = sl.res;
               n                = 2'd2;
               handled          = 1'b1;
            end else begin
               sl = content_step(st, CH_CR);
               st = sl.st;
               r0 = sl.res;
               n  = 2'd1;
            end
         end
         if (!handled) begin
            if (in_byte_ff == CH_CR && !in_last_ff) begin
               st.pending_cr = 1'b1;
            end else begin
               if (in_byte_ff == CH_LF) begin
                  sl = terminate_step(st);
               end else begin
                  sl = content_step(st, in_byte_ff);
               end
               st = sl.st;
               if (n == 2'd0) begin
                  r0 = sl.res;
               end else begin
                  r1 = sl.res;
               end
               n = n + 2'd1;
            end
         end
      end
      if (in_last_ff) begin
         if (n == 2'd2) begin
            r1.last_result   = 1'b1;
            r1.no_first_line = (st.phase == PH_START);
         end else begin
            r0.last_result   = 1'b1;
            r0.no_first_line = (st.phase == PH_START);
         end
         st = reset_state();
      end
      step_state      = st;
      step_push.count = n;
      step_push.slot0 = r0;
      step_push.slot1 = r1;
   end

   // Next state of the registers.
   always_comb begin
      state_in    = consume ? step_state : state_ff;
      in_valid_in = accept ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
      in_byte_in  = accept ? req.data_byte : in_byte_ff;
      in_last_in  = accept ? req.last_byte : in_last_ff;
   end

   // Results toward the result queue.
   always_comb begin
      push = step_push;
      if (!consume) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= reset_state();
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

endmodule

`default_nettype wire

[sv/smht_result_fifo.sv]
// ----------------------------------------------------------------------------
// smht_result_fifo
// Small result queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
`default_nettype none

module smht_result_fifo import smht_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire smht_push_type push,
   output logic          fifo_room,
   smht_rsp_if.source    rsp
);

   smht_result_type          entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]    count_ff, count_in;
   logic                     pop;
   smht_result_type          head;

   // Room for the largest burst of one transaction.
   assign fifo_room = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign pop       = rsp.valid && rsp.ready;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= push.slot1;
      end
   end

   assign rsp.valid         = (count_ff != '0);
   assign rsp.echo_byte     = head.echo_byte;
   assign rsp.in_start_line = head.in_start_line;
   assign rsp.response_flag = head.response_flag;
   assign rsp.method_done   = head.method_done;
   assign rsp.method_length = head.method_length;
   assign rsp.status_valid  = head.status_valid;
   assign rsp.status_chars  = head.status_chars;
   assign rsp.value_kind    = head.value_kind;
   assign rsp.value_commit  = head.value_commit;
   assign rsp.line_term     = head.line_term;
   assign rsp.no_first_line = head.no_first_line;
   assign rsp.last_result   = head.last_result;

endmodule

`default_nettype wire

[sv/smht_checker.sv]
// ----------------------------------------------------------------------------
// smht_checker
// Port-level checks of the SIP header tagger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module smht_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_in_start_line,
   input wire logic rsp_response_flag,
   input wire logic rsp_method_done,
   input wire logic rsp_status_valid,
   input wire logic rsp_value_commit,
   input wire logic rsp_line_term,
   input wire logic rsp_no_first_line,
   input wire logic rsp_last_result
);

   `SMHT_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SMHT_ASSERT_IMPLY(a_nofirst_last, clock, reset, rsp_valid && rsp_no_first_line, rsp_last_result)
   `SMHT_ASSERT_IMPLY(a_method_place, clock, reset, rsp_valid && rsp_method_done, rsp_in_start_line || rsp_line_term)
   `SMHT_ASSERT_IMPLY(a_status_resp, clock, reset, rsp_valid && rsp_status_valid, rsp_in_start_line && rsp_response_flag)
   `SMHT_ASSERT_IMPLY(a_commit_end, clock, reset, rsp_valid && rsp_value_commit, rsp_line_term)

endmodule

bind sip_message_header_tagger_unit smht_checker u_smht_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_in_start_line (rsp_chan.in_start_line),
   .rsp_response_flag (rsp_chan.response_flag),
   .rsp_method_done   (rsp_chan.method_done),
   .rsp_status_valid  (rsp_chan.status_valid),
   .rsp_value_commit  (rsp_chan.value_commit),
   .rsp_line_term     (rsp_chan.line_term),
   .rsp_no_first_line (rsp_chan.no_first_line),
   .rsp_last_result   (rsp_chan.last_result)
);

`default_nettype wire
